>>> rtl/pva_pkg.sv
// ----------------------------------------------------------------------------
// pva_pkg: shared types and constants of the voice allocator
// Payload structs, operation and register codes, and the command/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package pva_pkg;

  localparam int NOTE_W     = 7;
  localparam int VOICE_W    = 4;
  localparam int OPCODE_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  // Operation codes.
  localparam logic [OPCODE_W-1:0] OP_NOTE_ON   = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_NOTE_OFF  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_FIND      = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_CLR_NOTES = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_FULL_CLR  = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_VOICES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CYCLIC_MODE   = 2'd1;

  localparam logic [CFG_DATA_W-1:0] ACTIVE_VOICES_RST = 5'd16;
  localparam logic [NOTE_W-1:0]     NOTE_ALL_ONES     = 7'h7f;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [NOTE_W-1:0]   note;
  } pva_in_t;

  typedef struct packed {
    logic [VOICE_W-1:0] voice;
    logic               found;
  } pva_out_t;

  typedef enum logic [1:0] {
    SM_NOTE  = 2'd0,
    SM_LRU   = 2'd1,
    SM_TOUCH = 2'd2,
    SM_FILL  = 2'd3
  } scan_mode_t;

  typedef enum logic [1:0] {
    V_HIT = 2'd0,
    V_LRU = 2'd1,
    V_RR  = 2'd2
  } v_sel_t;

  typedef struct packed {
    logic       load;
    logic       scan_run;
    scan_mode_t scan_mode;
    logic       v_load;
    v_sel_t     v_sel;
    logic       rr_step;
    logic       vt_wr;
    logic       vt_ones;
    logic       act_clr;
    logic       clr_notes;
    logic       rl_head;
    logic       res_set;
    logic       res_found;
  } pva_cmd_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic                n_zero;
    logic                cyclic;
    logic                scan_done;
    logic                hit;
  } pva_sts_t;

endpackage

>>> rtl/pva_ctrl.sv
// ----------------------------------------------------------------------------
// pva_ctrl: operation sequencer of the voice allocator
// Walks each operation through its table scans, writes and result beat.
// ----------------------------------------------------------------------------
module pva_ctrl
  import pva_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output logic     out_valid,
  input  pva_sts_t sts,
  output pva_cmd_t cmd
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_DISPATCH = 10'b00_0000_0010,
    S_MATCH    = 10'b00_0000_0100,
    S_LRU      = 10'b00_0000_1000,
    S_RR       = 10'b00_0001_0000,
    S_WRITE    = 10'b00_0010_0000,
    S_TOUCH    = 10'b00_0100_0000,
    S_HEAD     = 10'b00_1000_0000,
    S_FILL     = 10'b01_0000_0000,
    S_DONE     = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts.op)
          OP_NOTE_ON: begin
            if (sts.n_zero) begin
              cmd.res_set = 1'b1;
              state_nxt   = S_DONE;
            end else if (sts.cyclic) begin
              state_nxt = S_RR;
            end else begin
              state_nxt = S_MATCH;
            end
          end
          OP_NOTE_OFF: begin
            if (sts.n_zero) begin
              cmd.res_set = 1'b1;
              state_nxt   = S_DONE;
            end else begin
              state_nxt = S_MATCH;
            end
          end
          OP_FIND: begin
            state_nxt = S_MATCH;
          end
          OP_CLR_NOTES: begin
            cmd.clr_notes = 1'b1;
            cmd.res_set   = 1'b1;
            state_nxt     = S_DONE;
          end
          OP_FULL_CLR: begin
            cmd.clr_notes = 1'b1;
            state_nxt     = S_FILL;
          end
          default: begin
            cmd.res_set = 1'b1;
            state_nxt   = S_DONE;
          end
        endcase
      end
      S_MATCH: begin
        cmd.scan_run  = 1'b1;
        cmd.scan_mode = SM_NOTE;
        if (sts.scan_done) begin
          cmd.v_load = 1'b1;
          cmd.v_sel  = V_HIT;
          if (sts.op == OP_FIND || !sts.hit) begin
            if (sts.op == OP_NOTE_ON) begin
              state_nxt = S_LRU;
            end else begin
              cmd.res_set   = 1'b1;
              cmd.res_found = sts.hit;
              state_nxt     = S_DONE;
            end
          end else begin
            state_nxt = S_WRITE;
          end
        end
      end
      S_LRU: begin
        cmd.scan_run  = 1'b1;
        cmd.scan_mode = SM_LRU;
        if (sts.scan_done) begin
          cmd.v_load = 1'b1;
          cmd.v_sel  = V_LRU;
          state_nxt  = S_WRITE;
        end
      end
      S_RR: begin
        cmd.rr_step = 1'b1;
        cmd.v_load  = 1'b1;
        cmd.v_sel   = V_RR;
        state_nxt   = S_WRITE;
      end
      S_WRITE: begin
        if (sts.op == OP_NOTE_OFF) begin
          if (sts.cyclic) begin
            // Round-robin release marks the entry with all ones.
            cmd.vt_wr     = 1'b1;
            cmd.vt_ones   = 1'b1;
            cmd.res_set   = 1'b1;
            cmd.res_found = 1'b1;
            state_nxt     = S_DONE;
          end else begin
            cmd.act_clr = 1'b1;
            state_nxt   = S_TOUCH;
          end
        end else begin
          cmd.vt_wr = 1'b1;
          state_nxt = S_TOUCH;
        end
      end
      S_TOUCH: begin
        cmd.scan_run  = 1'b1;
        cmd.scan_mode = SM_TOUCH;
        if (sts.scan_done) begin
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        cmd.rl_head   = 1'b1;
        cmd.res_set   = 1'b1;
        cmd.res_found = 1'b1;
        state_nxt     = S_DONE;
      end
      S_FILL: begin
        cmd.scan_run  = 1'b1;
        cmd.scan_mode = SM_FILL;
        if (sts.scan_done) begin
          cmd.res_set = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/pva_dp.sv
// ----------------------------------------------------------------------------
// pva_dp: voice table, recency list and scan engine
// Holds both tables in memories with one read and one write port, scans them
// one entry per cycle and keeps the configuration and result registers.
// ----------------------------------------------------------------------------
module pva_dp
  import pva_pkg::*;
#(
  parameter int VOICES = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pva_cmd_t              cmd,
  output pva_sts_t              sts,
  input  pva_in_t               in_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output pva_out_t              out_data
);

  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CW = $clog2(VOICES + 1);
  localparam logic [VW-1:0] TOP_VOICE = VW'(VOICES - 1);

  // Configuration.
  logic [CFG_DATA_W-1:0] active_voices_r;
  logic                  cyclic_r;
  logic [CW-1:0]         n_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_voices_r <= ACTIVE_VOICES_RST;
      cyclic_r        <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_ACTIVE_VOICES) begin
        active_voices_r <= cfg_data;
      end else if (cfg_index == CFG_CYCLIC_MODE) begin
        cyclic_r <= cfg_data[0];
      end
    end
  end

  always_comb begin
    if (8'(active_voices_r) < 8'(VOICES)) begin
      n_eff = CW'(active_voices_r);
    end else begin
      n_eff = CW'(VOICES);
    end
  end

  // Operation registers.
  logic [OPCODE_W-1:0] op_r;
  logic [NOTE_W-1:0]   note_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_data.opcode;
      note_r <= in_data.note;
    end
  end

  // Per-entry flags. An entry whose valid bit is clear reads as its reset value.
  logic [VOICES-1:0] act_r;
  logic [VOICES-1:0] ntv_r;
  logic [VOICES-1:0] rlv_r;

  // Scan engine.
  logic [CW-1:0] idx_r;
  logic [CW-1:0] dst_r;
  logic          dq_vld_r;
  logic [VW-1:0] dq_addr_r;
  logic          hit_r;
  logic [VW-1:0] hit_idx_r;
  logic          inact_r;
  logic [VW-1:0] inact_v_r;
  logic          any_r;
  logic [VW-1:0] any_v_r;
  logic [VW-1:0] v_r;
  logic [VW-1:0] rr_r;
  logic          found_r;

  logic [CW-1:0] rev_idx;
  logic [VW-1:0] rd_addr;
  logic          issue;
  logic          scan_done;

  assign rev_idx   = n_eff - idx_r - CW'(1);
  assign rd_addr   = (cmd.scan_mode == SM_TOUCH) ? rev_idx[VW-1:0] : idx_r[VW-1:0];
  assign issue     = cmd.scan_run && (idx_r != n_eff);
  assign scan_done = cmd.scan_run && (idx_r == n_eff) && !dq_vld_r;

  // Memories with registered read data.
  logic [NOTE_W-1:0] note_mem [VOICES];
  logic [VW-1:0]     rl_mem   [VOICES];
  logic [NOTE_W-1:0] nt_q;
  logic              ntv_q;
  logic [VW-1:0]     rl_q;
  logic              rlv_q;

  logic [NOTE_W-1:0] nt_wdata;
  logic              rl_we;
  logic [VW-1:0]     rl_waddr;
  logic [VW-1:0]     rl_wdata;

  assign nt_wdata = cmd.vt_ones ? NOTE_ALL_ONES : note_r;

  always_ff @(posedge clk) begin
    if (cmd.vt_wr) begin
      note_mem[v_r] <= nt_wdata;
    end
    nt_q  <= note_mem[rd_addr];
    ntv_q <= ntv_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rl_we) begin
      rl_mem[rl_waddr] <= rl_wdata;
    end
    rl_q  <= rl_mem[rd_addr];
    rlv_q <= rlv_r[rd_addr];
  end

  // Data stage of the scan.
  logic [NOTE_W-1:0] note_val;
  logic [VW-1:0]     rl_c;
  logic              rl_c_in;
  logic              note_match;
  logic              touch_wr;

  assign note_val   = ntv_q ? nt_q : '0;
  assign rl_c       = rlv_q ? rl_q : (TOP_VOICE - dq_addr_r);
  assign rl_c_in    = (CW'(rl_c) < n_eff);
  assign note_match = dq_vld_r && (cmd.scan_mode == SM_NOTE) && (note_val == note_r) &&
                      ((op_r != OP_FIND) || act_r[dq_addr_r]);
  assign touch_wr   = cmd.scan_run && dq_vld_r && (cmd.scan_mode == SM_TOUCH) &&
                      (rl_c != v_r);

  always_comb begin
    rl_we    = 1'b0;
    rl_waddr = '0;
    rl_wdata = v_r;
    if (cmd.rl_head) begin
      rl_we = 1'b1;
    end else if (touch_wr) begin
      rl_we    = 1'b1;
      rl_waddr = dst_r[VW-1:0];
      rl_wdata = rl_c;
    end else if (issue && (cmd.scan_mode == SM_FILL)) begin
      rl_we    = 1'b1;
      rl_waddr = idx_r[VW-1:0];
      rl_wdata = rev_idx[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      dst_r    <= '0;
      dq_vld_r <= 1'b0;
      hit_r    <= 1'b0;
      inact_r  <= 1'b0;
      any_r    <= 1'b0;
    end else if (!cmd.scan_run || scan_done) begin
      idx_r    <= '0;
      dst_r    <= n_eff - CW'(1);
      dq_vld_r <= 1'b0;
      hit_r    <= 1'b0;
      inact_r  <= 1'b0;
      any_r    <= 1'b0;
    end else begin
      if (issue) begin
        idx_r <= idx_r + CW'(1);
      end
      dq_vld_r <= issue && (cmd.scan_mode != SM_FILL);
      if (note_match && !hit_r) begin
        hit_r <= 1'b1;
      end
      if (dq_vld_r && (cmd.scan_mode == SM_LRU) && rl_c_in) begin
        any_r <= 1'b1;
        if (!act_r[rl_c]) begin
          inact_r <= 1'b1;
        end
      end
      if (touch_wr) begin
        dst_r <= dst_r - CW'(1);
      end
    end
  end

  // Payload side of the scan results.
  always_ff @(posedge clk) begin
    dq_addr_r <= rd_addr;
    if (note_match && !hit_r) begin
      hit_idx_r <= dq_addr_r;
    end
    if (dq_vld_r && (cmd.scan_mode == SM_LRU) && rl_c_in) begin
      any_v_r <= rl_c;
      if (!act_r[rl_c]) begin
        inact_v_r <= rl_c;
      end
    end
  end

  // Round-robin pick wraps to zero when it reaches the voice count.
  logic [VW:0]   rr_inc;
  logic [VW-1:0] rr_pick;

  assign rr_inc  = {1'b0, rr_r} + (VW + 1)'(1);
  assign rr_pick = (rr_inc >= (VW + 1)'(n_eff)) ? '0 : rr_inc[VW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rr_r <= '0;
    end else if (cmd.rr_step) begin
      rr_r <= rr_pick;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.v_load) begin
      unique case (cmd.v_sel)
        V_HIT: v_r <= hit_idx_r;
        V_LRU: begin
          if (inact_r) begin
            v_r <= inact_v_r;
          end else if (any_r) begin
            v_r <= any_v_r;
          end else begin
            v_r <= '0;
          end
        end
        V_RR:    v_r <= rr_pick;
        default: v_r <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (cmd.res_set) begin
      found_r <= cmd.res_found;
    end
  end

  // Entry flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= '0;
      ntv_r <= '0;
      rlv_r <= '0;
    end else begin
      if (cmd.clr_notes) begin
        for (int i = 0; i < VOICES; i++) begin
          if (CW'(i) < n_eff) begin
            act_r[i] <= 1'b0;
            ntv_r[i] <= 1'b0;
          end
        end
      end
      if (cmd.vt_wr) begin
        act_r[v_r] <= 1'b1;
        ntv_r[v_r] <= 1'b1;
      end
      if (cmd.act_clr) begin
        act_r[v_r] <= 1'b0;
      end
      if (rl_we) begin
        rlv_r[rl_waddr] <= 1'b1;
      end
    end
  end

  assign sts.op        = op_r;
  assign sts.n_zero    = (n_eff == '0);
  assign sts.cyclic    = cyclic_r;
  assign sts.scan_done = scan_done;
  assign sts.hit       = hit_r;

  assign out_data.voice = found_r ? VOICE_W'(v_r) : '0;
  assign out_data.found = found_r;

endmodule

>>> rtl/poly_voice_allocator_lru.sv
// ----------------------------------------------------------------------------
// poly_voice_allocator_lru: least-recently-used polyphonic voice allocator
// Assigns, releases and looks up synthesizer voices for note events.
// ----------------------------------------------------------------------------
// One operation is in flight at a time: start is taken while busy is low, and
// busy stays high until the result beat, which is on out_data for exactly one
// cycle with out_valid high and cannot be held off. Every table scan walks one
// entry per cycle through memories with one read and one write port, over the
// N entries of the effective voice count (active_voices capped at VOICES); the
// recency rebuild of a full clear writes its entries rather than reading them.
// A note on scans for its note and, on a miss, the recency list for the least
// recently used voice, inactive ones first; it then writes the voice and moves
// it to the head of the list. Round-robin note on picks the next voice without
// a scan. A note off that finds its voice marks it inactive and moves it to the
// head, or marks it with all ones in round-robin mode. When N is zero, note on
// and note off return not found without a scan. Configuration writes are always
// ready and belong in idle time. No clearing pass is needed after reset.
module poly_voice_allocator_lru
  import pva_pkg::*;
#(
  parameter int VOICES = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  pva_in_t               in_data,
  output logic                  out_valid,
  output pva_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  pva_cmd_t cmd;
  pva_sts_t sts;

  assign cfg_ready = 1'b1;

  pva_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  pva_dp #(
    .VOICES (VOICES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule
